### rtl/core/sbsu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the search/replace stack.
// No dependencies.
package sbsu_pkg;

    localparam int DATA_W    = 32;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_REPLACE = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Per-cycle command strobes broadcast to every cell.
    typedef struct packed {
        logic push;
        logic pop;
        logic repl;
        logic clr;
    } t_ctrl;

endpackage

### rtl/core/sbsu_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command and result items.
// Depends on sbsu_pkg.
interface sbsu_in_if;
    import sbsu_pkg::*;
    logic                     valid;
    logic                     ready;
    t_cmd                     cmd;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;

    modport source (output valid, output cmd, output value, output new_value, input ready);
    modport sink   (input valid, input cmd, input value, input new_value, output ready);
endinterface

interface sbsu_out_if;
    import sbsu_pkg::*;
    logic                     valid;
    logic                     ready;
    t_status                  status;
    logic [CNT_OUT_W-1:0]     entry_count;
    logic signed [DATA_W-1:0] top_value;

    modport source (output valid, output status, output entry_count, output top_value,
                    input ready);
    modport sink   (input valid, input status, input entry_count, input top_value,
                    output ready);
endinterface

### rtl/core/stack_with_search_update.sv
`timescale 1ns / 1ps
// Top level: bounded LIFO with search-and-replace, built as a row of cells.
// Depends on sbsu_pkg, sbsu_if, sbsu_cell.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------
//  i_in    | in  | valid/ready       | cmd, value, new_value
//  o_out   | out | valid/ready       | status, entry_count, top_value
//
// One command item per clock. The search for a replace ripples through the
// DEPTH per-cell comparators and their priority chain within that cycle.
// Each result sits in an output register; a new command is taken in the
// same cycle the previous result is taken, so a stalled sink holds one result
// and the command port stalls until it clears.
// Synchronous active-low reset empties the stack (occupied flags, count) and
// drops any pending result; stored words are not cleared.
module stack_with_search_update import sbsu_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbsu_in_if.sink    i_in,
    sbsu_out_if.source o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Cell 0 holds the top of stack; entries shift down on push, up on pop.
    logic signed [DATA_W-1:0] w_data   [DEPTH];
    logic signed [DATA_W-1:0] w_n_data [DEPTH];
    logic [DEPTH-1:0]         w_occ;
    logic [DEPTH-1:0]         w_n_occ;
    logic [DEPTH-1:0]         w_match;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_full;
    logic             w_empty;
    logic             w_accept;
    logic             w_in_ready;
    t_ctrl            w_ctrl;
    t_status          n_status;

    logic                     r_out_valid;
    t_status                  r_status;
    logic [CNT_OUT_W-1:0]     r_count;
    logic signed [DATA_W-1:0] r_top;

    assign w_full     = (r_cnt == CNT_W'(DEPTH));
    assign w_empty    = (r_cnt == '0);
    assign w_in_ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    // Full pushes and empty pops are dropped here so the cells never move.
    always_comb begin
        w_ctrl.push = w_accept && (i_in.cmd == CMD_PUSH) && !w_full;
        w_ctrl.pop  = w_accept && (i_in.cmd == CMD_POP) && !w_empty;
        w_ctrl.repl = w_accept && (i_in.cmd == CMD_REPLACE);
        w_ctrl.clr  = w_accept && (i_in.cmd == CMD_CLEAR);
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [DATA_W-1:0] w_above_data;
            logic signed [DATA_W-1:0] w_below_data;
            logic                     w_above_occ;
            logic                     w_below_occ;
            logic                     w_match_above;

            if (g == 0) begin : g_top
                assign w_above_data  = i_in.value;
                assign w_above_occ   = 1'b1;
                assign w_match_above = 1'b0;
            end else begin : g_mid
                assign w_above_data  = w_data[g-1];
                assign w_above_occ   = w_occ[g-1];
                assign w_match_above = w_match[g-1];
            end

            if (g == DEPTH - 1) begin : g_bot
                assign w_below_data = '0;
                assign w_below_occ  = 1'b0;
            end else begin : g_up
                assign w_below_data = w_data[g+1];
                assign w_below_occ  = w_occ[g+1];
            end

            sbsu_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_value       (i_in.value),
                .i_new_value   (i_in.new_value),
                .i_above_data  (w_above_data),
                .i_above_occ   (w_above_occ),
                .i_below_data  (w_below_data),
                .i_below_occ   (w_below_occ),
                .i_match_above (w_match_above),
                .o_data        (w_data[g]),
                .o_occ         (w_occ[g]),
                .o_match       (w_match[g]),
                .o_n_data      (w_n_data[g]),
                .o_n_occ       (w_n_occ[g])
            );
        end
    endgenerate

    always_comb begin
        n_cnt = r_cnt;
        if (w_ctrl.clr) begin
            n_cnt = '0;
        end else if (w_ctrl.push) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_ctrl.pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_comb begin
        n_status = ST_DONE;
        case (i_in.cmd)
            CMD_PUSH:    if (w_full)  n_status = ST_FULL;
            CMD_POP:     if (w_empty) n_status = ST_POP_EMPTY;
            CMD_REPLACE: if (!w_match[DEPTH-1]) n_status = ST_NOT_FOUND;
            CMD_CLEAR:   n_status = ST_DONE;
            default:     n_status = ST_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_status <= n_status;
            r_count  <= CNT_OUT_W'(n_cnt);
            r_top    <= w_n_occ[0] ? w_n_data[0] : '0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.entry_count = r_count;
    assign o_out.top_value   = r_top;

    // Occupied flags form a thermometer that must track the count.
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) == !w_occ[0])
        else $error("top cell occupancy disagrees with count");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occ[DEPTH-1] == w_full)
        else $error("bottom cell occupancy disagrees with count");

    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.push |=> (r_cnt == $past(r_cnt) + CNT_W'(1)) && w_occ[0])
        else $error("push did not grow the stack");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.clr |=> (r_cnt == '0) && (w_occ == '0))
        else $error("clear left entries behind");

endmodule

### rtl/core/sbsu_cell.sv
`timescale 1ns / 1ps
// One stack slot: data word, occupied flag, compare for search/replace.
// Depends on sbsu_pkg.
module sbsu_cell import sbsu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl                    i_ctrl,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_new_value,
    input  logic signed [DATA_W-1:0] i_above_data,
    input  logic                     i_above_occ,
    input  logic signed [DATA_W-1:0] i_below_data,
    input  logic                     i_below_occ,
    input  logic                     i_match_above,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_occ,
    output logic                     o_match,
    output logic signed [DATA_W-1:0] o_n_data,
    output logic                     o_n_occ
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     r_occ;
    logic                     n_occ;
    logic                     w_hit;

    assign w_hit = r_occ && (r_data == i_value);

    always_comb begin
        n_data = r_data;
        if (i_ctrl.push) begin
            n_data = i_above_data;
        end else if (i_ctrl.pop) begin
            n_data = i_below_data;
        end else if (i_ctrl.repl && w_hit && !i_match_above) begin
            n_data = i_new_value;   // first match from the top only
        end
    end

    always_comb begin
        n_occ = r_occ;
        if (i_ctrl.clr) begin
            n_occ = 1'b0;
        end else if (i_ctrl.push) begin
            n_occ = i_above_occ;
        end else if (i_ctrl.pop) begin
            n_occ = i_below_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_data   = r_data;
    assign o_occ    = r_occ;
    assign o_match  = i_match_above | w_hit;
    assign o_n_data = n_data;
    assign o_n_occ  = n_occ;

endmodule

### verif/stack_with_search_update_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the search/replace stack: mirrors the stack from accepted
// commands and checks every result item. Depends on sbsu_pkg and sbsu_if.
module stack_with_search_update_checker import sbsu_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sbsu_in_if   i_in,
    sbsu_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        t_status              status;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [DATA_W-1:0]    top_value;
    } t_stack_result;

    logic [DATA_W-1:0] mirror_words [DEPTH];
    int                mirror_fill;
    t_stack_result     result_q [$];
    int                mismatch_total = 0;
    int                pending_total  = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = pending_total;

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("ERROR %0t: %s: got 0x%h, want 0x%h", $time, what, got, want);
        mismatch_total++;
    endtask

    // Applies one command to the mirror and returns the result it must produce.
    function automatic t_stack_result apply_command(t_cmd cmd, logic [DATA_W-1:0] key,
                                                    logic [DATA_W-1:0] repl);
        t_stack_result res;
        bit            hit;
        res.status = ST_DONE;
        case (cmd)
            CMD_PUSH: begin
                if (mirror_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    mirror_words[mirror_fill] = key;
                    mirror_fill++;
                end
            end
            CMD_POP: begin
                if (mirror_fill == 0) begin
                    res.status = ST_POP_EMPTY;
                end else begin
                    mirror_fill--;
                end
            end
            CMD_REPLACE: begin
                // first match from the top wins
                hit = 1'b0;
                for (int i = mirror_fill - 1; i >= 0; i--) begin
                    if (!hit && mirror_words[i] == key) begin
                        mirror_words[i] = repl;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    res.status = ST_NOT_FOUND;
                end
            end
            default: begin
                mirror_fill = 0;
            end
        endcase
        res.entry_count = CNT_OUT_W'(mirror_fill);
        res.top_value   = (mirror_fill > 0) ? mirror_words[mirror_fill - 1] : '0;
        return res;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_stack_result got;
        t_stack_result want;
        if (!i_rst_n) begin
            mirror_fill = 0;
            result_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = {i_out.status, i_out.entry_count, i_out.top_value};
                if (result_q.size() == 0) begin
                    report_mismatch("result item with nothing pending, top_value",
                                    got.top_value, '0);
                end else begin
                    want = result_q.pop_front();
                    if (got.status !== want.status) begin
                        report_mismatch("status", DATA_W'(got.status),
                                        DATA_W'(want.status));
                    end
                    if (got.entry_count !== want.entry_count) begin
                        report_mismatch("entry_count", DATA_W'(got.entry_count),
                                        DATA_W'(want.entry_count));
                    end
                    if (got.top_value !== want.top_value) begin
                        report_mismatch("top_value", got.top_value, want.top_value);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                result_q.push_back(apply_command(i_in.cmd, i_in.value, i_in.new_value));
            end
        end
        pending_total = result_q.size();
    end

endmodule

### verif/stack_with_search_update_tb.sv
`timescale 1ns / 1ps
// Top of the stack testbench: clock, reset, command stimulus, result sink
// with stalls, watchdog and verdict. Depends on sbsu_pkg, sbsu_if, the
// stack RTL and stack_with_search_update_checker.
module stack_with_search_update_tb;
    import sbsu_pkg::*;

    localparam int STACK_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1800;
    // Quiet stretches come from sink holds and from sender gaps.
    localparam int IDLE_LIMIT   = 3000;

    // Sink behavior per segment.
    typedef enum {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_HOLD
    } t_sink_mode;

    // Shape of the random command stream: grow toward full, shrink toward
    // empty, or hover in between with more replaces.
    typedef enum {
        PH_FILL,
        PH_DRAIN,
        PH_CHURN
    } t_walk_phase;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   burst_left;

    sbsu_in_if  cmd_ch ();
    sbsu_out_if res_ch ();

    stack_with_search_update #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (cmd_ch),
        .o_out  (res_ch)
    );

    stack_with_search_update_checker #(
        .DEPTH(STACK_DEPTH)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (cmd_ch),
        .i_out       (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: any handshake on either channel counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("stack_with_search_update_tb failed");
            $finish;
        end
    end

    // Offers one command item and returns at the edge that accepts it.
    // Bursts of back-to-back items are separated by random gaps; within a
    // burst valid stays high, so it is never dropped and raised in one step.
    task automatic send_cmd(t_cmd cmd, logic [DATA_W-1:0] key, logic [DATA_W-1:0] repl);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 6);
            if (gap > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.cmd       <= cmd;
        cmd_ch.value     <= key;
        cmd_ch.new_value <= repl;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        burst_left--;
    endtask

    // Result side: segments of always-ready, coin-flip, sparse and held-off
    // ready. One long hold is forced early so the output register fills and
    // the command port has to back-pressure while items are still offered.
    initial begin : result_sink
        t_sink_mode mode;
        int         roll;
        int         seg_cycles;
        int         run_cycles;
        bit         long_hold_done;
        res_ch.ready <= 1'b0;
        run_cycles     = 0;
        long_hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            roll = $urandom_range(0, 19);
            if (roll < 7) begin
                mode = SINK_OPEN;
            end else if (roll < 14) begin
                mode = SINK_COIN;
            end else if (roll < 19) begin
                mode = SINK_SPARSE;
            end else begin
                mode = SINK_HOLD;
            end
            if (!long_hold_done && run_cycles >= 400) begin
                mode           = SINK_HOLD;
                long_hold_done = 1'b1;
            end
            seg_cycles = (mode == SINK_HOLD) ? $urandom_range(150, 300) : $urandom_range(4, 60);
            repeat (seg_cycles) begin
                case (mode)
                    SINK_OPEN:   res_ch.ready <= 1'b1;
                    SINK_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:     res_ch.ready <= 1'b0;
                endcase
                @(posedge clk);
                run_cycles++;
            end
        end
    end

    initial begin : stimulus
        logic [DATA_W-1:0] pool [8];
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] repl;
        t_walk_phase       phase;
        t_cmd              cmd;
        int                roll;
        int                push_cut;
        int                pop_cut;
        int                repl_cut;

        // every block input known from time zero
        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.cmd       <= CMD_PUSH;
        cmd_ch.value     <= '0;
        cmd_ch.new_value <= '0;
        burst_left  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        send_cmd(CMD_POP, '0, '0);                      // pop on empty
        send_cmd(CMD_REPLACE, '0, 32'h1111_1111);       // replace on empty
        send_cmd(CMD_PUSH, 32'h8000_0000, '0);          // most negative
        send_cmd(CMD_PUSH, 32'h7FFF_FFFF, '0);          // most positive
        send_cmd(CMD_PUSH, 32'hFFFF_FFFF, '0);
        send_cmd(CMD_PUSH, 32'h0000_0000, '1);
        send_cmd(CMD_PUSH, 32'h7FFF_FFFF, '0);          // duplicate of entry 1
        // two matches: the upper copy changes first, then the lower one
        send_cmd(CMD_REPLACE, 32'h7FFF_FFFF, 32'h5555_5555);
        send_cmd(CMD_REPLACE, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
        send_cmd(CMD_REPLACE, 32'h1234_5678, 32'h8765_4321);   // no match
        send_cmd(CMD_POP, '0, '0);
        repeat (STACK_DEPTH - 4) send_cmd(CMD_PUSH, $urandom, '0);   // fill up
        send_cmd(CMD_PUSH, 32'hDEAD_BEEF, '0);          // push on full, dropped
        send_cmd(CMD_CLEAR, '0, '0);
        send_cmd(CMD_POP, '0, '0);                      // empty again after clear

        // --- random ---
        // Values come mostly from a small pool so replaces find matches and
        // replaced values get searched again; the pool itself drifts.
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        for (int i = 2; i < 8; i++) begin
            pool[i] = $urandom;
        end
        phase = PH_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0:       phase = PH_FILL;
                    1:       phase = PH_DRAIN;
                    default: phase = PH_CHURN;
                endcase
            end
            case (phase)
                PH_FILL: begin
                    push_cut = 70; pop_cut = 80; repl_cut = 98;
                end
                PH_DRAIN: begin
                    push_cut = 15; pop_cut = 80; repl_cut = 98;
                end
                default: begin
                    push_cut = 40; pop_cut = 70; repl_cut = 97;
                end
            endcase
            if ($urandom_range(0, 19) == 0) begin
                pool[$urandom_range(0, 7)] = $urandom;
            end
            key  = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)] : $urandom;
            repl = ($urandom_range(0, 1) == 1) ? pool[$urandom_range(0, 7)] : $urandom;
            roll = $urandom_range(0, 99);
            if (roll < push_cut) begin
                cmd = CMD_PUSH;
            end else if (roll < pop_cut) begin
                cmd = CMD_POP;
            end else if (roll < repl_cut) begin
                cmd = CMD_REPLACE;
            end else begin
                cmd = CMD_CLEAR;
            end
            send_cmd(cmd, key, repl);
        end
        cmd_ch.valid <= 1'b0;

        // drain: sample the checker's count away from the clock edge
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("stack_with_search_update_tb passed");
        end else begin
            $display("stack_with_search_update_tb failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/sbsu_pkg.sv
rtl/core/sbsu_if.sv
rtl/core/sbsu_cell.sv
rtl/core/stack_with_search_update.sv
verif/stack_with_search_update_checker.sv
verif/stack_with_search_update_tb.sv
